FILE: src/vrptw_route_cost_evaluator_assert.svh
// Assertion macros shared by the route cost evaluator modules.
// RCE_ASSERT_IMPL checks a consequent in the same cycle as its antecedent.
// RCE_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef VRPTW_ROUTE_COST_EVALUATOR_ASSERT_SVH
`define VRPTW_ROUTE_COST_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define RCE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("route cost evaluator: same-cycle check failed");

`define RCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route cost evaluator: next-cycle check failed");

`else

`define RCE_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define RCE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/rce_pkg.sv
package rce_pkg;

    // Default number of fraction bits in the lateness weight.
    localparam int unsigned RCE_FRAC_BITS = 8;

    // Configuration port geometry.
    localparam int unsigned RCE_CFG_IDX_W  = 2;
    localparam int unsigned RCE_CFG_DATA_W = 16;

    localparam logic [15:0] RCE_CAPACITY_RESET = 16'd0;
    localparam logic [15:0] RCE_LATE_W_RESET   = 16'd256;
    localparam logic [15:0] RCE_OVER_W_RESET   = 16'd256;

    typedef enum logic [RCE_CFG_IDX_W-1:0] {
        CFG_VEHICLE_CAPACITY = 2'd0,
        CFG_LATENESS_WEIGHT  = 2'd1,
        CFG_OVERLOAD_WEIGHT  = 2'd2
    } t_cfg_index;

    // One customer visit.
    typedef struct packed {
        logic [23:0] travel_in;
        logic [9:0]  demand;
        logic [23:0] window_open;
        logic [23:0] window_close;
        logic [23:0] service_time;
        logic        route_end;
        logic [23:0] return_travel;
        logic [23:0] depot_close;
        logic        solution_end;
    } t_visit;

    // One route result.
    typedef struct packed {
        logic [15:0] route_index;
        logic [31:0] route_distance;
        logic [31:0] finish_time;
        logic [15:0] route_load;
        logic [15:0] route_overload;
        logic [31:0] route_lateness;
        logic        totals_valid;
        logic [39:0] total_distance;
        logic [39:0] total_lateness;
        logic [31:0] total_overload;
        logic [56:0] objective;
    } t_route;

    // Pipeline control handed from the top level to the stages.
    typedef struct packed {
        logic advance;
        logic accept;
    } t_pipe_ctrl;

endpackage

FILE: src/rce_visit_if.sv
interface rce_visit_if import rce_pkg::*; ();
    logic   valid;
    logic   ready;
    t_visit data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/rce_route_if.sv
interface rce_route_if import rce_pkg::*; ();
    logic   valid;
    logic   ready;
    t_route data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/rce_visit.sv
`include "vrptw_route_cost_evaluator_assert.svh"

module rce_visit import rce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctrl  i_ctrl,
    input  t_visit      i_visit,
    input  logic [15:0] i_capacity,
    output logic        o_route_valid,
    output t_route      o_route
);

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? '1 : s[15:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [39:0] sat40(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? '1 : s[39:0];
    endfunction

    // Input register.
    logic        r_in_v;
    t_visit      r_in;

    // Route and solution state.
    logic [31:0] r_clock;
    logic [15:0] r_load;
    logic [31:0] r_route_dist;
    logic [31:0] r_route_late;
    logic [15:0] r_route_count;
    logic [39:0] r_dist_total;
    logic [39:0] r_late_total;
    logic [31:0] r_over_total;

    // Result register.
    logic        r_route_v;
    t_route      r_route;

    logic [31:0] travel32, wopen32, wclose32, svc32, ret32, dclose32;
    logic [31:0] clk_arrive, clk_start, clk_leave, clk_home;
    logic [31:0] late_visit, late_home, dist_visit, dist_home;
    logic [15:0] load_new, overload;
    logic [39:0] dist_tot_new, late_tot_new;
    logic [31:0] over_tot_new;
    t_route      n_route;
    logic        step;

    assign step = i_ctrl.advance && r_in_v;

    always_comb begin
        travel32 = {8'd0, r_in.travel_in};
        wopen32  = {8'd0, r_in.window_open};
        wclose32 = {8'd0, r_in.window_close};
        svc32    = {8'd0, r_in.service_time};
        ret32    = {8'd0, r_in.return_travel};
        dclose32 = {8'd0, r_in.depot_close};

        // Visit: arrive, wait for the window, charge lateness, serve.
        clk_arrive = sat32(r_clock, travel32);
        clk_start  = (clk_arrive < wopen32) ? wopen32 : clk_arrive;
        late_visit = (clk_start > wclose32) ? sat32(r_route_late, clk_start - wclose32)
                                            : r_route_late;
        clk_leave  = sat32(clk_start, svc32);
        dist_visit = sat32(r_route_dist, travel32);
        load_new   = sat16(r_load, {6'd0, r_in.demand});

        // Return to the depot on the last visit of a route.
        clk_home  = sat32(clk_leave, ret32);
        late_home = (clk_home > dclose32) ? sat32(late_visit, clk_home - dclose32)
                                          : late_visit;
        dist_home = sat32(dist_visit, ret32);
        overload  = (load_new > i_capacity) ? load_new - i_capacity : 16'd0;

        dist_tot_new = sat40(r_dist_total, {8'd0, dist_home});
        late_tot_new = sat40(r_late_total, {8'd0, late_home});
        over_tot_new = sat32(r_over_total, {16'd0, overload});

        n_route                = '0;
        n_route.route_index    = r_route_count;
        n_route.route_distance = dist_home;
        n_route.finish_time    = clk_home;
        n_route.route_load     = load_new;
        n_route.route_overload = overload;
        n_route.route_lateness = late_home;
        if (r_in.solution_end) begin
            n_route.totals_valid   = 1'b1;
            n_route.total_distance = dist_tot_new;
            n_route.total_lateness = late_tot_new;
            n_route.total_overload = over_tot_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v        <= 1'b0;
            r_route_v     <= 1'b0;
            r_clock       <= '0;
            r_load        <= '0;
            r_route_dist  <= '0;
            r_route_late  <= '0;
            r_route_count <= '0;
            r_dist_total  <= '0;
            r_late_total  <= '0;
            r_over_total  <= '0;
        end else if (i_ctrl.advance) begin
            r_in_v    <= i_ctrl.accept;
            r_route_v <= r_in_v && r_in.route_end;
            if (r_in_v) begin
                if (!r_in.route_end) begin
                    r_clock      <= clk_leave;
                    r_load       <= load_new;
                    r_route_dist <= dist_visit;
                    r_route_late <= late_visit;
                end else begin
                    r_clock      <= '0;
                    r_load       <= '0;
                    r_route_dist <= '0;
                    r_route_late <= '0;
                    if (r_in.solution_end) begin
                        r_route_count <= '0;
                        r_dist_total  <= '0;
                        r_late_total  <= '0;
                        r_over_total  <= '0;
                    end else begin
                        r_route_count <= r_route_count + 16'd1;
                        r_dist_total  <= dist_tot_new;
                        r_late_total  <= late_tot_new;
                        r_over_total  <= over_tot_new;
                    end
                end
            end
        end
    end

    // Payload registers load only when the stage moves.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_in    <= i_visit;
            r_route <= n_route;
        end
    end

    assign o_route_valid = r_route_v;
    assign o_route       = r_route;

    `RCE_ASSERT_NEXT(a_route_state_clears, i_clk, i_rst_n,
        step && r_in.route_end,
        (r_clock == '0) && (r_load == '0) && (r_route_dist == '0) && (r_route_late == '0))

    `RCE_ASSERT_NEXT(a_solution_state_clears, i_clk, i_rst_n,
        step && r_in.route_end && r_in.solution_end,
        (r_route_count == '0) && (r_dist_total == '0) && (r_late_total == '0)
            && (r_over_total == '0))

    `RCE_ASSERT_IMPL(a_totals_zero_unless_final, i_clk, i_rst_n,
        r_route_v && !r_route.totals_valid,
        (r_route.total_distance == '0) && (r_route.total_lateness == '0)
            && (r_route.total_overload == '0))

endmodule

FILE: src/rce_objective.sv
`include "vrptw_route_cost_evaluator_assert.svh"

module rce_objective import rce_pkg::*; #(
    parameter int unsigned FRAC_BITS = RCE_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctrl  i_ctrl,
    input  logic        i_route_valid,
    input  t_route      i_route,
    input  logic [15:0] i_late_weight,
    input  logic [15:0] i_over_weight,
    output logic        o_route_valid,
    output t_route      o_route
);

    // The 16 x 40 lateness product is formed from two 16 x 20 halves.
    localparam int unsigned SPLIT = 20;

    logic        r_v2, r_v3, r_v4;
    t_route      r_r2, r_r3, r_r4;
    logic [35:0] r_p_lo, r_p_hi;
    logic [47:0] r_p_over;
    logic [55:0] r_prod;
    logic [48:0] r_base;

    logic [35:0] n_p_lo, n_p_hi;
    logic [47:0] n_p_over;
    logic [55:0] n_prod, late_part;
    logic [48:0] n_base;
    t_route      n_r4;

    always_comb begin
        n_p_lo   = i_late_weight * i_route.total_lateness[SPLIT-1:0];
        n_p_hi   = i_late_weight * i_route.total_lateness[39:SPLIT];
        n_p_over = i_over_weight * i_route.total_overload;

        n_prod = {r_p_hi, {SPLIT{1'b0}}} + {{SPLIT{1'b0}}, r_p_lo};
        n_base = {9'd0, r_r2.total_distance} + {1'b0, r_p_over};

        late_part      = r_prod >> FRAC_BITS;
        n_r4           = r_r3;
        n_r4.objective = 57'(r_base) + 57'(late_part);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_v2 <= i_route_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_r2     <= i_route;
            r_p_lo   <= n_p_lo;
            r_p_hi   <= n_p_hi;
            r_p_over <= n_p_over;
            r_r3     <= r_r2;
            r_prod   <= n_prod;
            r_base   <= n_base;
            r_r4     <= n_r4;
        end
    end

    assign o_route_valid = r_v4;
    assign o_route       = r_r4;

    `RCE_ASSERT_IMPL(a_objective_zero_unless_final, i_clk, i_rst_n,
        r_v4 && !r_r4.totals_valid,
        r_r4.objective == '0)

    `RCE_ASSERT_IMPL(a_objective_covers_distance, i_clk, i_rst_n,
        r_v4 && r_r4.totals_valid,
        r_r4.objective >= 57'(r_r4.total_distance))

    `RCE_ASSERT_IMPL(a_objective_distance_only, i_clk, i_rst_n,
        r_v4 && (r_r4.total_lateness == '0) && (r_r4.total_overload == '0),
        r_r4.objective == 57'(r_r4.total_distance))

endmodule

FILE: src/vrptw_route_cost_evaluator.sv
// Route cost evaluator for vehicle routing with time windows.
//
// Input channel i_visit takes one customer visit per word: the travel from
// the previous stop, demand, time window and service time, and on the last
// visit of a route also the return travel and the depot closing time.
// Output channel o_route gives one word per finished route; on the final
// route of a solution it also carries the totals and the weighted objective.
// Visits in the middle of a route produce no output word.
//
// A visit word can be taken on every clock cycle unless the pipeline holds.
// The edge that accepts a closing visit loads the input register; the route
// word then passes the route stage that holds the per-route clock and sums,
// a stage that forms the weight partial products, a stage that joins them,
// and the final adder stage. The route clock recurrence is closed inside the
// route stage, so consecutive visits of one route need no spacing.
//
// When the receiver holds o_route.ready low with a word pending, the whole pipeline
// holds and i_visit.ready falls in the same cycle. Reset clears the route and
// solution state and loads the configuration defaults. The user must write registers
// through i_cfg_we, i_cfg_index and i_cfg_data only while idle; the block has no check.
module vrptw_route_cost_evaluator import rce_pkg::*; #(
    parameter int unsigned FRAC_BITS = RCE_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [RCE_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [RCE_CFG_DATA_W-1:0] i_cfg_data,
    rce_visit_if.sink                 i_visit,
    rce_route_if.source               o_route
);

    // Configuration registers.
    logic [15:0] r_capacity;
    logic [15:0] r_late_weight;
    logic [15:0] r_over_weight;

    t_pipe_ctrl ctrl;
    logic       route_valid, obj_valid;
    t_route     route_word, obj_word;

    // The pipeline moves whenever the output register is empty or drained.
    assign ctrl.advance  = !obj_valid || o_route.ready;
    assign ctrl.accept   = i_visit.valid && ctrl.advance;
    assign i_visit.ready = ctrl.advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= RCE_CAPACITY_RESET;
            r_late_weight <= RCE_LATE_W_RESET;
            r_over_weight <= RCE_OVER_W_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VEHICLE_CAPACITY: r_capacity    <= i_cfg_data;
                CFG_LATENESS_WEIGHT:  r_late_weight <= i_cfg_data;
                CFG_OVERLOAD_WEIGHT:  r_over_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rce_visit u_visit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_visit       (i_visit.data),
        .i_capacity    (r_capacity),
        .o_route_valid (route_valid),
        .o_route       (route_word)
    );

    rce_objective #(
        .FRAC_BITS (FRAC_BITS)
    ) u_objective (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_route_valid (route_valid),
        .i_route       (route_word),
        .i_late_weight (r_late_weight),
        .i_over_weight (r_over_weight),
        .o_route_valid (obj_valid),
        .o_route       (obj_word)
    );

    assign o_route.valid = obj_valid;
    assign o_route.data  = obj_word;

endmodule
